// ===== hdl/ljte_pkg.sv =====
// Shared types, codes and the micro-program of the LED junction temperature estimator.
// No dependencies; used by ljte_dp, ljte_ctrl and the top level (ljte_div does not use it).
package ljte_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_RED_RATIO   = 3'd0;
  localparam logic [2:0] CFG_GREEN_RATIO = 3'd1;
  localparam logic [2:0] CFG_BLUE_RATIO  = 3'd2;
  localparam logic [2:0] CFG_CHIP_RATIO  = 3'd3;
  localparam logic [2:0] CFG_OVER_RATING = 3'd4;
  localparam logic [2:0] CFG_UNDER_RATING = 3'd5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [14:0] RATIO_RESET = 15'd100;

  // Program counter width (program is 84 words long)
  localparam int unsigned PC_W = 7;

  typedef struct packed {
    logic [11:0] die_adc;
    logic [15:0] duty_red;
    logic [15:0] duty_green;
    logic [15:0] duty_blue;
    logic [15:0] volt_red;
    logic [15:0] volt_green;
    logic [15:0] volt_blue;
    logic [14:0] supply_mv;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] led_temp;
    logic signed [15:0] chip_temp;
    logic               refreshed;
  } out_word_t;

  // Accumulator operations
  typedef enum logic [2:0] {
    OP_LD, OP_ADD, OP_SUB, OP_RSUB, OP_MUL, OP_DIV, OP_W16, OP_ST
  } op_e;

  // Operand sources
  typedef enum logic [5:0] {
    S_NONE, S_ADCR, S_K1000, S_K3959, S_K125, S_TS, S_X, S_J, S_H, S_DIEF, S_K2,
    S_DUTY0, S_DUTY1, S_DUTY2, S_MV0, S_MV1, S_MV2,
    S_RAT0, S_RAT1, S_RAT2, S_RAT3, S_PWM, S_K21, S_P, S_BAT, S_C, S_BDEV,
    S_RATG, S_K10, S_A, S_K1M, S_DIEN, S_K10TS, S_LEDF, S_K15, S_K16, S_T,
    S_R, S_K19, S_K20
  } src_e;

  // Scratch register targets
  typedef enum logic [3:0] {
    D_NONE, D_X, D_J, D_H, D_P, D_C, D_A, D_T, D_R, D_L
  } dst_e;

  typedef struct packed {
    logic done;
    op_e  op;
    src_e src;
    dst_e dst;
  } instr_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic   load;
    logic   exec;
    logic   commit;
    instr_t instr;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic div_done;
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_EXEC, ST_DIV, ST_COMMIT
  } state_e;

  function automatic instr_t mk(input op_e op, input src_e src, input dst_e dst);
    instr_t r;
    r.done = 1'b0;
    r.op   = op;
    r.src  = src;
    r.dst  = dst;
    return r;
  endfunction

  // Micro-program: one word per step of the estimate
  function automatic instr_t prog(input logic [PC_W-1:0] pc);
    instr_t r;
    r = '{done: 1'b1, op: OP_LD, src: S_NONE, dst: D_NONE};
    unique case (pc)
      // die temperature
      7'd0:  r = mk(OP_LD,   S_ADCR,  D_NONE);
      7'd1:  r = mk(OP_MUL,  S_K1000, D_NONE);
      7'd2:  r = mk(OP_DIV,  S_K3959, D_NONE);
      7'd3:  r = mk(OP_RSUB, S_K125,  D_NONE);
      7'd4:  r = mk(OP_MUL,  S_TS,    D_NONE);
      7'd5:  r = mk(OP_ST,   S_NONE,  D_X);
      7'd6:  r = mk(OP_W16,  S_NONE,  D_NONE);
      7'd7:  r = mk(OP_ST,   S_NONE,  D_J);
      7'd8:  r = mk(OP_LD,   S_DIEF,  D_NONE);
      7'd9:  r = mk(OP_ADD,  S_X,     D_NONE);
      7'd10: r = mk(OP_W16,  S_NONE,  D_NONE);
      7'd11: r = mk(OP_DIV,  S_K2,    D_NONE);
      7'd12: r = mk(OP_ST,   S_NONE,  D_H);
      // red power
      7'd13: r = mk(OP_LD,   S_DUTY0, D_NONE);
      7'd14: r = mk(OP_MUL,  S_MV0,   D_NONE);
      7'd15: r = mk(OP_DIV,  S_PWM,   D_NONE);
      7'd16: r = mk(OP_MUL,  S_RAT0,  D_NONE);
      7'd17: r = mk(OP_MUL,  S_K21,   D_NONE);
      7'd18: r = mk(OP_ST,   S_NONE,  D_P);
      // green power
      7'd19: r = mk(OP_LD,   S_DUTY1, D_NONE);
      7'd20: r = mk(OP_MUL,  S_MV1,   D_NONE);
      7'd21: r = mk(OP_DIV,  S_PWM,   D_NONE);
      7'd22: r = mk(OP_MUL,  S_RAT1,  D_NONE);
      7'd23: r = mk(OP_MUL,  S_K21,   D_NONE);
      7'd24: r = mk(OP_ADD,  S_P,     D_NONE);
      7'd25: r = mk(OP_ST,   S_NONE,  D_P);
      // blue power
      7'd26: r = mk(OP_LD,   S_DUTY2, D_NONE);
      7'd27: r = mk(OP_MUL,  S_MV2,   D_NONE);
      7'd28: r = mk(OP_DIV,  S_PWM,   D_NONE);
      7'd29: r = mk(OP_MUL,  S_RAT2,  D_NONE);
      7'd30: r = mk(OP_MUL,  S_K21,   D_NONE);
      7'd31: r = mk(OP_ADD,  S_P,     D_NONE);
      7'd32: r = mk(OP_ST,   S_NONE,  D_P);
      // driver drop power
      7'd33: r = mk(OP_LD,   S_BAT,   D_NONE);
      7'd34: r = mk(OP_SUB,  S_MV0,   D_NONE);
      7'd35: r = mk(OP_MUL,  S_DUTY0, D_NONE);
      7'd36: r = mk(OP_ST,   S_NONE,  D_C);
      7'd37: r = mk(OP_LD,   S_BAT,   D_NONE);
      7'd38: r = mk(OP_SUB,  S_MV1,   D_NONE);
      7'd39: r = mk(OP_MUL,  S_DUTY1, D_NONE);
      7'd40: r = mk(OP_ADD,  S_C,     D_NONE);
      7'd41: r = mk(OP_ST,   S_NONE,  D_C);
      7'd42: r = mk(OP_LD,   S_BAT,   D_NONE);
      7'd43: r = mk(OP_SUB,  S_MV2,   D_NONE);
      7'd44: r = mk(OP_MUL,  S_DUTY2, D_NONE);
      7'd45: r = mk(OP_ADD,  S_C,     D_NONE);
      7'd46: r = mk(OP_ST,   S_NONE,  D_C);
      // supply rating adjustment
      7'd47: r = mk(OP_LD,   S_BDEV,  D_NONE);
      7'd48: r = mk(OP_DIV,  S_K1000, D_NONE);
      7'd49: r = mk(OP_MUL,  S_RATG,  D_NONE);
      7'd50: r = mk(OP_DIV,  S_K10,   D_NONE);
      7'd51: r = mk(OP_W16,  S_NONE,  D_NONE);
      7'd52: r = mk(OP_ADD,  S_RAT3,  D_NONE);
      7'd53: r = mk(OP_ST,   S_NONE,  D_A);
      // chip power, difference, junction estimate
      7'd54: r = mk(OP_LD,   S_C,     D_NONE);
      7'd55: r = mk(OP_DIV,  S_PWM,   D_NONE);
      7'd56: r = mk(OP_MUL,  S_A,     D_NONE);
      7'd57: r = mk(OP_MUL,  S_K21,   D_NONE);
      7'd58: r = mk(OP_ST,   S_NONE,  D_C);
      7'd59: r = mk(OP_LD,   S_BAT,   D_NONE);
      7'd60: r = mk(OP_MUL,  S_K10,   D_NONE);
      7'd61: r = mk(OP_MUL,  S_RAT3,  D_NONE);
      7'd62: r = mk(OP_ADD,  S_C,     D_NONE);
      7'd63: r = mk(OP_SUB,  S_P,     D_NONE);
      7'd64: r = mk(OP_DIV,  S_K1M,   D_NONE);
      7'd65: r = mk(OP_MUL,  S_TS,    D_NONE);
      7'd66: r = mk(OP_RSUB, S_DIEN,  D_NONE);
      7'd67: r = mk(OP_W16,  S_NONE,  D_NONE);
      7'd68: r = mk(OP_ADD,  S_K10TS, D_NONE);
      7'd69: r = mk(OP_W16,  S_NONE,  D_NONE);
      7'd70: r = mk(OP_ST,   S_NONE,  D_T);
      // cascaded filters
      7'd71: r = mk(OP_LD,   S_LEDF,  D_NONE);
      7'd72: r = mk(OP_MUL,  S_K15,   D_NONE);
      7'd73: r = mk(OP_ADD,  S_T,     D_NONE);
      7'd74: r = mk(OP_DIV,  S_K16,   D_NONE);
      7'd75: r = mk(OP_W16,  S_NONE,  D_NONE);
      7'd76: r = mk(OP_ST,   S_NONE,  D_R);
      7'd77: r = mk(OP_LD,   S_LEDF,  D_NONE);
      7'd78: r = mk(OP_MUL,  S_K19,   D_NONE);
      7'd79: r = mk(OP_ADD,  S_R,     D_NONE);
      7'd80: r = mk(OP_DIV,  S_K20,   D_NONE);
      7'd81: r = mk(OP_W16,  S_NONE,  D_NONE);
      7'd82: r = mk(OP_ST,   S_NONE,  D_L);
      default: r = '{done: 1'b1, op: OP_LD, src: S_NONE, dst: D_NONE};
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ljte_div.sv =====
// Signed 32-bit divider for constant divisors, truncating toward zero: reciprocal
// multiply, then one remainder correction. Depends on nothing; instantiated by ljte_dp.
module ljte_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] dividend_i,
  input  logic signed [31:0] divisor_i,
  input  logic [31:0]        recip_i,     // floor((2^32-1) / |divisor|)
  output logic               done_o,
  output logic signed [31:0] quotient_o
);

  logic        mul_q, fix_q, done_q;
  logic [31:0] nmag_q, dmag_q, recip_q, qest_q, quo_q;
  logic        neg_q;
  logic [63:0] prod;
  logic [31:0] rem;

  // estimate is the true quotient or one below it
  always_comb begin
    prod = {32'd0, nmag_q} * {32'd0, recip_q};
    rem  = nmag_q - 32'(qest_q * dmag_q);
  end

  // stage valids: start -> multiply -> correct -> done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      fix_q  <= mul_q;
      done_q <= fix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nmag_q  <= dividend_i[31] ? 32'(-dividend_i) : 32'(dividend_i);
      dmag_q  <= divisor_i[31] ? 32'(-divisor_i) : 32'(divisor_i);
      recip_q <= recip_i;
      neg_q   <= dividend_i[31] ^ divisor_i[31];
    end
    if (mul_q) qest_q <= prod[63:32];
    if (fix_q) quo_q <= qest_q + {31'd0, (rem >= dmag_q)};
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ===== hdl/ljte_dp.sv =====
// Datapath: input latch, config registers, accumulator with shared multiplier and
// divider, scratch registers, filter state and output word. Uses ljte_pkg, ljte_div.
module ljte_dp #(
  parameter int TEMP_SCALE     = 10,
  parameter int PWM_FULL_SCALE = 1000,
  parameter int REFRESH_MS     = 250
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ljte_pkg::cmd_t                     cmd_i,
  output ljte_pkg::status_t                  status_o,
  input  ljte_pkg::in_word_t                 in_word_i,
  input  logic                               cfg_we_i,
  input  logic [ljte_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ljte_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output ljte_pkg::out_word_t                out_word_o
);

  localparam logic signed [31:0] KTS    = 32'(TEMP_SCALE);
  localparam logic signed [31:0] KPWM   = 32'(PWM_FULL_SCALE);
  localparam logic signed [31:0] K10TS  = 32'(10 * TEMP_SCALE);
  localparam logic [31:0]        KREFR  = 32'(REFRESH_MS);

  // reciprocals of the constant divisors
  localparam logic [63:0] RCP_NUM  = 64'hFFFF_FFFF;
  localparam logic [31:0] RCP_2    = 32'(RCP_NUM / 64'd2);
  localparam logic [31:0] RCP_10   = 32'(RCP_NUM / 64'd10);
  localparam logic [31:0] RCP_16   = 32'(RCP_NUM / 64'd16);
  localparam logic [31:0] RCP_20   = 32'(RCP_NUM / 64'd20);
  localparam logic [31:0] RCP_1000 = 32'(RCP_NUM / 64'd1000);
  localparam logic [31:0] RCP_3959 = 32'(RCP_NUM / 64'd3959);
  localparam logic [31:0] RCP_1M   = 32'(RCP_NUM / 64'd1000000);
  localparam logic [31:0] RCP_PWM  = 32'(RCP_NUM / 64'(PWM_FULL_SCALE));

  ljte_pkg::in_word_t in_q;
  logic [14:0] rat_q [4];
  logic [14:0] over_q, under_q;

  logic signed [31:0] acc_q, acc_d;
  logic signed [31:0] x_q, j_q, h_q, p_q, c_q, a_q, t_q, r_q, l_q;
  logic signed [15:0] die_q, led_q, pre_q, led_held_q, chip_held_q;
  logic               seeded_q;
  logic [31:0]        last_q;
  ljte_pkg::out_word_t out_q;

  logic signed [31:0] opnd;
  logic [31:0]        recip;
  logic signed [31:0] adcr;
  logic [11:0]        adc_c;
  logic signed [31:0] bat;
  logic               bat_hi;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_quo;
  logic signed [15:0] die_new, led_new, pre_new;
  logic [31:0]        tick_gap;
  logic               refresh;

  // clamped, offset ADC reading and supply terms
  always_comb begin
    adc_c = in_q.die_adc;
    if (adc_c >= 12'd4090) adc_c = 12'd4090;
    if (adc_c <= 12'd10)   adc_c = 12'd10;
    adcr   = $signed({20'd0, adc_c}) - 32'sd1205;
    bat    = $signed({17'd0, in_q.supply_mv});
    bat_hi = (in_q.supply_mv >= 15'd12000);
  end

  // operand select
  always_comb begin
    unique case (cmd_i.instr.src)
      ljte_pkg::S_ADCR:  opnd = adcr;
      ljte_pkg::S_K1000: opnd = 32'sd1000;
      ljte_pkg::S_K3959: opnd = 32'sd3959;
      ljte_pkg::S_K125:  opnd = 32'sd125;
      ljte_pkg::S_TS:    opnd = KTS;
      ljte_pkg::S_X:     opnd = x_q;
      ljte_pkg::S_J:     opnd = j_q;
      ljte_pkg::S_H:     opnd = h_q;
      ljte_pkg::S_DIEF:  opnd = 32'(die_q);
      ljte_pkg::S_K2:    opnd = 32'sd2;
      ljte_pkg::S_DUTY0: opnd = $signed({16'd0, in_q.duty_red});
      ljte_pkg::S_DUTY1: opnd = $signed({16'd0, in_q.duty_green});
      ljte_pkg::S_DUTY2: opnd = $signed({16'd0, in_q.duty_blue});
      ljte_pkg::S_MV0:   opnd = $signed({16'd0, in_q.volt_red});
      ljte_pkg::S_MV1:   opnd = $signed({16'd0, in_q.volt_green});
      ljte_pkg::S_MV2:   opnd = $signed({16'd0, in_q.volt_blue});
      ljte_pkg::S_RAT0:  opnd = $signed({17'd0, rat_q[0]});
      ljte_pkg::S_RAT1:  opnd = $signed({17'd0, rat_q[1]});
      ljte_pkg::S_RAT2:  opnd = $signed({17'd0, rat_q[2]});
      ljte_pkg::S_RAT3:  opnd = $signed({17'd0, rat_q[3]});
      ljte_pkg::S_PWM:   opnd = KPWM;
      ljte_pkg::S_K21:   opnd = 32'sd21;
      ljte_pkg::S_P:     opnd = p_q;
      ljte_pkg::S_BAT:   opnd = bat;
      ljte_pkg::S_C:     opnd = c_q;
      ljte_pkg::S_BDEV:  opnd = bat_hi ? bat - 32'sd12000 : 32'sd12000 - bat;
      ljte_pkg::S_RATG:  opnd = $signed({17'd0, bat_hi ? over_q : under_q});
      ljte_pkg::S_K10:   opnd = 32'sd10;
      ljte_pkg::S_A:     opnd = a_q;
      ljte_pkg::S_K1M:   opnd = 32'sd1000000;
      ljte_pkg::S_DIEN:  opnd = seeded_q ? h_q : j_q;
      ljte_pkg::S_K10TS: opnd = K10TS;
      ljte_pkg::S_LEDF:  opnd = 32'(led_q);
      ljte_pkg::S_K15:   opnd = 32'sd15;
      ljte_pkg::S_K16:   opnd = 32'sd16;
      ljte_pkg::S_T:     opnd = t_q;
      ljte_pkg::S_R:     opnd = r_q;
      ljte_pkg::S_K19:   opnd = 32'sd19;
      ljte_pkg::S_K20:   opnd = 32'sd20;
      default:           opnd = '0;
    endcase
  end

  // reciprocal of the divisor operand
  always_comb begin
    unique case (cmd_i.instr.src)
      ljte_pkg::S_K2:    recip = RCP_2;
      ljte_pkg::S_K10:   recip = RCP_10;
      ljte_pkg::S_K16:   recip = RCP_16;
      ljte_pkg::S_K20:   recip = RCP_20;
      ljte_pkg::S_K1000: recip = RCP_1000;
      ljte_pkg::S_K3959: recip = RCP_3959;
      ljte_pkg::S_K1M:   recip = RCP_1M;
      ljte_pkg::S_PWM:   recip = RCP_PWM;
      default:           recip = '0;
    endcase
  end

  // accumulator update
  assign div_start = cmd_i.exec && !cmd_i.instr.done && (cmd_i.instr.op == ljte_pkg::OP_DIV);

  always_comb begin
    acc_d = acc_q;
    if (div_done) begin
      acc_d = div_quo;
    end else if (cmd_i.exec && !cmd_i.instr.done) begin
      unique case (cmd_i.instr.op)
        ljte_pkg::OP_LD:   acc_d = opnd;
        ljte_pkg::OP_ADD:  acc_d = acc_q + opnd;
        ljte_pkg::OP_SUB:  acc_d = acc_q - opnd;
        ljte_pkg::OP_RSUB: acc_d = opnd - acc_q;
        ljte_pkg::OP_MUL:  acc_d = 32'(acc_q * opnd);
        ljte_pkg::OP_W16:  acc_d = 32'($signed(acc_q[15:0]));
        ljte_pkg::OP_DIV,
        ljte_pkg::OP_ST:   acc_d = acc_q;
        default:           acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.load) in_q <= in_word_i;
    if (cmd_i.exec && !cmd_i.instr.done && cmd_i.instr.op == ljte_pkg::OP_ST) begin
      unique case (cmd_i.instr.dst)
        ljte_pkg::D_X: x_q <= acc_q;
        ljte_pkg::D_J: j_q <= acc_q;
        ljte_pkg::D_H: h_q <= acc_q;
        ljte_pkg::D_P: p_q <= acc_q;
        ljte_pkg::D_C: c_q <= acc_q;
        ljte_pkg::D_A: a_q <= acc_q;
        ljte_pkg::D_T: t_q <= acc_q;
        ljte_pkg::D_R: r_q <= acc_q;
        ljte_pkg::D_L: l_q <= acc_q;
        default: ;
      endcase
    end
  end

  ljte_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (opnd),
    .recip_i    (recip),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign status_o.div_done = div_done;

  // commit values
  always_comb begin
    die_new  = seeded_q ? h_q[15:0] : j_q[15:0];
    led_new  = seeded_q ? l_q[15:0] : t_q[15:0];
    pre_new  = seeded_q ? r_q[15:0] : pre_q;
    tick_gap = in_q.now_ms - (last_q + KREFR);
    refresh  = !seeded_q || (!tick_gap[31] && (tick_gap != '0));
  end

  // config registers and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rat_q[0]    <= ljte_pkg::RATIO_RESET;
      rat_q[1]    <= ljte_pkg::RATIO_RESET;
      rat_q[2]    <= ljte_pkg::RATIO_RESET;
      rat_q[3]    <= ljte_pkg::RATIO_RESET;
      over_q      <= '0;
      under_q     <= '0;
      die_q       <= '0;
      led_q       <= '0;
      pre_q       <= '0;
      seeded_q    <= 1'b0;
      last_q      <= '0;
      led_held_q  <= '0;
      chip_held_q <= '0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ljte_pkg::CFG_RED_RATIO:    rat_q[0] <= cfg_wdata_i;
          ljte_pkg::CFG_GREEN_RATIO:  rat_q[1] <= cfg_wdata_i;
          ljte_pkg::CFG_BLUE_RATIO:   rat_q[2] <= cfg_wdata_i;
          ljte_pkg::CFG_CHIP_RATIO:   rat_q[3] <= cfg_wdata_i;
          ljte_pkg::CFG_OVER_RATING:  over_q   <= cfg_wdata_i;
          ljte_pkg::CFG_UNDER_RATING: under_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        die_q    <= die_new;
        led_q    <= led_new;
        pre_q    <= pre_new;
        seeded_q <= 1'b1;
        if (refresh) begin
          last_q      <= in_q.now_ms;
          led_held_q  <= led_new;
          chip_held_q <= die_new;
        end
        out_q.led_temp  <= refresh ? led_new : led_held_q;
        out_q.chip_temp <= refresh ? die_new : chip_held_q;
        out_q.refreshed <= refresh;
      end
    end
  end

  assign out_word_o = out_q;

endmodule

// ===== hdl/ljte_ctrl.sv =====
// Controller: handshake, program counter and sequencing of the datapath program.
// Uses ljte_pkg.
module ljte_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ljte_pkg::cmd_t    cmd_o,
  input  ljte_pkg::status_t status_i
);

  ljte_pkg::state_e         state_q, state_d;
  logic [ljte_pkg::PC_W-1:0] pc_q, pc_d;
  logic                     out_valid_q, out_valid_d;
  ljte_pkg::instr_t         instr;
  logic                     is_div;

  assign instr  = ljte_pkg::prog(pc_q);
  assign is_div = !instr.done && (instr.op == ljte_pkg::OP_DIV);

  // next state
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      ljte_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ljte_pkg::ST_EXEC;
          pc_d    = '0;
        end
      end
      ljte_pkg::ST_EXEC: begin
        if (instr.done) begin
          state_d = ljte_pkg::ST_COMMIT;
        end else if (is_div) begin
          state_d = ljte_pkg::ST_DIV;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
      ljte_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ljte_pkg::ST_EXEC;
          pc_d    = pc_q + 1'b1;
        end
      end
      ljte_pkg::ST_COMMIT: begin
        if (!out_valid_q || out_ready_i) state_d = ljte_pkg::ST_IDLE;
      end
      default: state_d = ljte_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = (state_q == ljte_pkg::ST_IDLE);
    cmd_o.load   = in_ready_o && in_valid_i;
    cmd_o.exec   = (state_q == ljte_pkg::ST_EXEC);
    cmd_o.commit = (state_q == ljte_pkg::ST_COMMIT) && (!out_valid_q || out_ready_i);
    cmd_o.instr  = instr;
    out_valid_d  = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit)               out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ljte_pkg::ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a commit always leaves a word waiting
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q) else $error("commit did not raise out_valid");

  // a divide step always parks the controller until the quotient returns
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ljte_pkg::ST_EXEC && is_div) |=> (state_q == ljte_pkg::ST_DIV))
    else $error("divide step not followed by wait");

  // quotients only arrive while waiting for one
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == ljte_pkg::ST_DIV))
    else $error("divider done outside wait state");

endmodule

// ===== hdl/led_junction_temp_estimator.sv =====
// Top level of the LED junction temperature estimator: controller plus datapath.
// Uses ljte_pkg, ljte_ctrl, ljte_dp (which holds ljte_div).
//
// One sample word in, one result word out. Each sample runs an 83-step program on a
// single accumulator with a combinational 32x32 multiplier; divides are all by constants
// and go through a reciprocal-multiply unit, which the controller waits on in ST_DIV.
// Eleven steps are divides. After the program comes the end-of-program word, then the
// commit, which waits while an earlier result word is still unread on the output.
// A new sample is taken once the previous one has finished, even while its result
// word is still waiting on the output register. Config writes take effect at once
// and are meant for idle periods.
module led_junction_temp_estimator #(
  parameter int TEMP_SCALE     = 10,
  parameter int PWM_FULL_SCALE = 1000,
  parameter int REFRESH_MS     = 250
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ljte_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ljte_pkg::out_word_t             out_word_o,
  input  logic                            cfg_we_i,
  input  logic [ljte_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ljte_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  ljte_pkg::cmd_t    cmd;
  ljte_pkg::status_t status;

  ljte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ljte_dp #(
    .TEMP_SCALE     (TEMP_SCALE),
    .PWM_FULL_SCALE (PWM_FULL_SCALE),
    .REFRESH_MS     (REFRESH_MS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== tb/tb_led_junction_temp_estimator.sv =====
// Testbench for led_junction_temp_estimator: random and directed samples checked
// against an in-bench predictor of the temperature estimate. Depends on ljte_pkg.
`timescale 1ns / 100ps

module tb_led_junction_temp_estimator;

  localparam int TEMP_SCALE     = 10;
  localparam int PWM_FULL_SCALE = 1000;
  localparam int REFRESH_MS     = 250;
  localparam int N_RANDOM       = 1030;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ljte_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ljte_pkg::out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [ljte_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [ljte_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  led_junction_temp_estimator i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [14:0] ratio [4];
  logic [14:0] over_rating, under_rating;
  logic signed [15:0] die_filt, led_filt, led_pre, led_held, chip_held;
  logic seeded;
  logic [31:0] last_refresh;

  ljte_pkg::in_word_t samples_pending[$];
  ljte_pkg::out_word_t temps_expected[$];
  int errors = 0;
  int words_checked = 0;
  int refresh_count = 0;
  longint cycle_count = 0;
  bit no_idle = 1'b0;

  function automatic logic signed [15:0] w16(input logic signed [31:0] v);
    return v[15:0];
  endfunction

  // Compute the published temperatures for one sample and advance the state
  function automatic ljte_pkg::out_word_t estimate_temps(input ljte_pkg::in_word_t s);
    ljte_pkg::out_word_t r;
    logic signed [31:0] adc, joint, p, pled, pchip, adj, chip, bat, diff, t;
    logic signed [15:0] adj16, t16, hsum;
    logic [31:0] dl;
    logic refresh;
    logic [15:0] duty [3];
    logic [15:0] mv [3];
    duty[0] = s.duty_red; duty[1] = s.duty_green; duty[2] = s.duty_blue;
    mv[0] = s.volt_red; mv[1] = s.volt_green; mv[2] = s.volt_blue;
    adc = s.die_adc;
    if (adc >= 4090) adc = 4090;
    if (adc <= 10) adc = 10;
    joint = 125 - ((adc - 1205) * 1000 / 3959);
    if (!seeded) die_filt = w16(joint * TEMP_SCALE);
    else begin
      hsum = w16(die_filt + joint * TEMP_SCALE);
      die_filt = w16(hsum / 2);
    end
    bat = s.supply_mv;
    pled = 0;
    pchip = 0;
    for (int i = 0; i < 3; i++) begin
      p = ($signed({16'd0, duty[i]}) * $signed({16'd0, mv[i]})) / PWM_FULL_SCALE;
      p = p * $signed({17'd0, ratio[i]});
      pled = pled + p * 21;
      pchip = pchip + $signed({16'd0, duty[i]}) * (bat - $signed({16'd0, mv[i]}));
    end
    if (bat >= 12000) adj = (bat - 12000) / 1000 * $signed({17'd0, over_rating}) / 10;
    else adj = (12000 - bat) / 1000 * $signed({17'd0, under_rating}) / 10;
    adj16 = w16(adj);
    chip = $signed({17'd0, ratio[3]});
    pchip = (pchip / PWM_FULL_SCALE) * (chip + adj16);
    pchip = pchip * 21 + (10 * bat) * chip;
    diff = pchip - pled;
    t = die_filt - (diff / 1000000) * TEMP_SCALE;
    t16 = w16(t);
    t16 = w16(t16 + 10 * TEMP_SCALE);
    if (!seeded) led_filt = t16;
    else begin
      led_pre = w16((led_filt * 15 + t16) / 16);
      led_filt = w16((led_filt * 19 + led_pre) / 20);
    end
    dl = s.now_ms - (last_refresh + REFRESH_MS);
    refresh = !seeded || $signed(dl) > 0;
    if (refresh) begin
      last_refresh = s.now_ms;
      led_held = led_filt;
      chip_held = die_filt;
    end
    seeded = 1'b1;
    r.led_temp = led_held;
    r.chip_temp = chip_held;
    r.refreshed = refresh;
    return r;
  endfunction

  // Driver: present pending samples, idling at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        temps_expected.push_back(estimate_temps(in_word_i));
        void'(samples_pending.pop_front());
      end
      if ((!in_valid_i || in_ready_o) ) begin
        if (in_valid_i && in_ready_o && samples_pending.size() == 0) in_valid_i <= 1'b0;
        else if (samples_pending.size() > 0 &&
                 (no_idle || $urandom_range(99) >= 29)) begin
          in_valid_i <= 1'b1;
          in_word_i <= samples_pending[0];
        end else in_valid_i <= 1'b0;
      end
      out_ready_i <= no_idle || $urandom_range(99) >= 29;
    end
  end

  // Monitor: check each result word against the oldest expectation
  always @(posedge clk_i) begin
    ljte_pkg::out_word_t e;
    cycle_count++;
    if (out_valid_o && out_ready_i) begin
      if (temps_expected.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        e = temps_expected.pop_front();
        words_checked++;
        if (e.refreshed) refresh_count++;
        if (out_word_o.led_temp !== e.led_temp) begin
          $error("led_temp expected %0d actual %0d", e.led_temp, out_word_o.led_temp);
          errors++;
        end
        if (out_word_o.chip_temp !== e.chip_temp) begin
          $error("chip_temp expected %0d actual %0d", e.chip_temp, out_word_o.chip_temp);
          errors++;
        end
        if (out_word_o.refreshed !== e.refreshed) begin
          $error("refreshed expected %0d actual %0d", e.refreshed, out_word_o.refreshed);
          errors++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic cfg_write(input logic [ljte_pkg::CFG_IDX_W-1:0] idx,
                           input logic [14:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ljte_pkg::CFG_RED_RATIO:   ratio[0] = val;
      ljte_pkg::CFG_GREEN_RATIO: ratio[1] = val;
      ljte_pkg::CFG_BLUE_RATIO:  ratio[2] = val;
      ljte_pkg::CFG_CHIP_RATIO:  ratio[3] = val;
      ljte_pkg::CFG_OVER_RATING: over_rating = val;
      default:                   under_rating = val;
    endcase
  endtask

  // Wait until every sample is consumed and every word has arrived
  task automatic drain();
    while (samples_pending.size() != 0 || in_valid_i || temps_expected.size() != 0)
      @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  function automatic ljte_pkg::in_word_t rand_sample(input logic [31:0] tick);
    ljte_pkg::in_word_t s;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    s = raw[$bits(ljte_pkg::in_word_t)-1:0];
    s.now_ms = tick;
    if ($urandom_range(3) != 0) begin
      // realistic operating point
      s.duty_red = 16'($urandom_range(1000));
      s.duty_green = 16'($urandom_range(1000));
      s.duty_blue = 16'($urandom_range(1000));
      s.volt_red = 16'($urandom_range(3500, 1500));
      s.volt_green = 16'($urandom_range(3500, 1500));
      s.volt_blue = 16'($urandom_range(3500, 1500));
      s.supply_mv = 15'($urandom_range(20000, 6000));
    end
    return s;
  endfunction

  task automatic rand_phase(input int n, inout logic [31:0] tick);
    for (int i = 0; i < n; i++) begin
      tick += ($urandom_range(9) == 0) ? $urandom : $urandom_range(400);
      samples_pending.push_back(rand_sample(tick));
    end
  endtask

  initial begin
    ljte_pkg::in_word_t s;
    logic [31:0] tick;
    for (int i = 0; i < 4; i++) ratio[i] = ljte_pkg::RATIO_RESET;
    over_rating = '0; under_rating = '0;
    die_filt = '0; led_filt = '0; led_pre = '0; led_held = '0; chip_held = '0;
    seeded = 1'b0; last_refresh = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ADC clamps, field extremes, tick boundary and wrap
    tick = 32'd1000;
    s = '0; s.now_ms = tick; samples_pending.push_back(s);
    s = '1; s.now_ms = tick + REFRESH_MS; samples_pending.push_back(s);
    s.now_ms = tick + REFRESH_MS + 1; samples_pending.push_back(s);
    s = '0; s.die_adc = 10; s.supply_mv = 12000; s.now_ms = tick + 600;
    samples_pending.push_back(s);
    s.die_adc = 11; s.supply_mv = 11999; s.now_ms = tick + 900; samples_pending.push_back(s);
    s.die_adc = 4090; s.supply_mv = 13000; s.duty_red = 1000; s.volt_red = 3000;
    s.now_ms = tick + 1200; samples_pending.push_back(s);
    s.die_adc = 4089; s.supply_mv = 32767; s.duty_green = 65535; s.volt_green = 65535;
    s.now_ms = 32'hFFFF_FF00; samples_pending.push_back(s);
    s.die_adc = 1205; s.supply_mv = 0; s.duty_blue = 65535; s.volt_blue = 0;
    s.now_ms = 32'h0000_0020; samples_pending.push_back(s);
    s.now_ms = 32'h7FFF_FFFF; samples_pending.push_back(s);
    drain();

    // Register extremes with a rating active both ways
    cfg_write(ljte_pkg::CFG_RED_RATIO, 15'h7FFF);
    cfg_write(ljte_pkg::CFG_GREEN_RATIO, 15'd0);
    cfg_write(ljte_pkg::CFG_BLUE_RATIO, 15'd1);
    cfg_write(ljte_pkg::CFG_CHIP_RATIO, 15'h7FFF);
    cfg_write(ljte_pkg::CFG_OVER_RATING, 15'h7FFF);
    cfg_write(ljte_pkg::CFG_UNDER_RATING, 15'h7FFF);
    tick = 32'd5000;
    for (int i = 0; i < 8; i++) begin
      s = rand_sample(tick + i * 300);
      s.supply_mv = (i % 2) ? 15'd32767 : 15'd0;
      samples_pending.push_back(s);
    end
    drain();

    // Random settings per phase; the first phase runs with no idling
    for (int ph = 0; ph < 5; ph++) begin
      no_idle = (ph == 0);
      cfg_write(ljte_pkg::CFG_RED_RATIO, 15'($urandom_range(400)));
      cfg_write(ljte_pkg::CFG_GREEN_RATIO, 15'($urandom_range(400)));
      cfg_write(ljte_pkg::CFG_BLUE_RATIO, 15'($urandom_range(400)));
      cfg_write(ljte_pkg::CFG_CHIP_RATIO, (ph == 4) ? 15'd0 : 15'($urandom_range(400)));
      cfg_write(ljte_pkg::CFG_OVER_RATING, 15'($urandom));
      cfg_write(ljte_pkg::CFG_UNDER_RATING, 15'($urandom_range(200)));
      rand_phase(N_RANDOM / 5, tick);
      drain();
    end
    no_idle = 1'b0;

    $display("checked %0d result words (%0d refreshes) over directed and random samples",
             words_checked, refresh_count);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
